FILE: rtl/srmp_pkg.sv
// shared constants, types and tables of the stereo ring mixer
`timescale 1ns / 1ps
package srmp_pkg;

  localparam int RING_DEPTH_DEF = 4096;
  localparam int OUT_RATE       = 44100;
  localparam int HALF_RATE      = OUT_RATE / 2;
  localparam int PWM_TOP        = 1699;
  localparam int PWM_SPAN       = PWM_TOP + 1;
  localparam int PWM_W          = $clog2(PWM_SPAN);
  localparam int PHASE_W        = $clog2(OUT_RATE);
  localparam int RATE_W         = $clog2(OUT_RATE + 1);
  localparam int SAMPLE_W       = 16;
  localparam int PLAYER_W       = 17;
  localparam int FRAME_W        = 16;
  localparam int FREQ_W         = 15;
  localparam int VOL_W          = 7;
  localparam int LEVEL_W        = 8;
  localparam int SCALE_W        = 9;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int VOL_MAX        = 100;
  localparam int FREQ_MIN       = 20;
  localparam int FREQ_MAX       = 20000;
  localparam int FREQ_RESET     = 440;
  localparam int SCALE_RESET    = 256;
  localparam int LEVEL_RESET    = 128;
  // floor(v * 256 / 100) == (v * SCALE_RECIP) >> SCALE_SHIFT for v in 0..100
  localparam int SCALE_RECIP    = 167773;
  localparam int SCALE_SHIFT    = 16;
  localparam int SCALE_PROD_W   = 25;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME       = 2'd0,
    REG_TONE_ENABLE  = 2'd1,
    REG_TONE_FREQ    = 2'd2,
    REG_CONTENT_RATE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                tone_enable;
    logic                tone_clear;
    logic [FREQ_W-1:0]   tone_freq;
    logic [LEVEL_W-1:0]  tone_level;
    logic [SCALE_W-1:0]  scale;
  } mix_cfg_t;

  typedef struct packed {
    logic                       kind;
    logic                       underrun;
    logic                       dropped;
    logic [FRAME_W-1:0]         frame;
    logic signed [PLAYER_W-1:0] player_left;
    logic signed [PLAYER_W-1:0] player_right;
  } job_t;

  localparam logic [LEVEL_W-1:0] LOG_LEVEL [0:VOL_MAX] = '{
    8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,
    8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd7,   8'd8,
    8'd8,   8'd9,   8'd9,   8'd10,  8'd10,  8'd11,  8'd12,  8'd12,  8'd13,  8'd14,
    8'd14,  8'd15,  8'd15,  8'd16,  8'd17,  8'd18,  8'd18,  8'd19,  8'd20,  8'd21,
    8'd22,  8'd22,  8'd23,  8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd29,  8'd30,
    8'd31,  8'd32,  8'd33,  8'd34,  8'd35,  8'd36,  8'd37,  8'd39,  8'd40,  8'd41,
    8'd42,  8'd44,  8'd45,  8'd46,  8'd48,  8'd49,  8'd51,  8'd52,  8'd54,  8'd55,
    8'd57,  8'd59,  8'd60,  8'd62,  8'd64,  8'd66,  8'd68,  8'd70,  8'd71,  8'd73,
    8'd76,  8'd78,  8'd80,  8'd82,  8'd84,  8'd86,  8'd89,  8'd91,  8'd94,  8'd96,
    8'd99,  8'd101, 8'd104, 8'd107, 8'd110, 8'd113, 8'd115, 8'd119, 8'd122, 8'd125,
    8'd128
  };

endpackage

FILE: rtl/srmp_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
interface srmp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic signed [srmp_pkg::SAMPLE_W-1:0] sample_left;
  logic signed [srmp_pkg::SAMPLE_W-1:0] sample_right;
  logic signed [srmp_pkg::PLAYER_W-1:0] player_left;
  logic signed [srmp_pkg::PLAYER_W-1:0] player_right;

  modport source (output valid, kind, sample_left, sample_right, player_left, player_right,
                  input ready);
  modport sink (input valid, kind, sample_left, sample_right, player_left, player_right,
                output ready);
endinterface

interface srmp_out_if #(
  parameter int USED_W = $clog2(srmp_pkg::RING_DEPTH_DEF + 1)
);
  logic                         valid;
  logic                         ready;
  logic [srmp_pkg::PWM_W-1:0]   pwm_left;
  logic [srmp_pkg::PWM_W-1:0]   pwm_right;
  logic                         underrun;
  logic                         dropped;
  logic [USED_W-1:0]            fill_level;

  modport source (output valid, pwm_left, pwm_right, underrun, dropped, fill_level,
                  input ready);
  modport sink (input valid, pwm_left, pwm_right, underrun, dropped, fill_level,
                output ready);
endinterface

FILE: rtl/srmp_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module srmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/srmp_front.sv
// front end: request intake, ring pointers, ring writes and resampled reads
`timescale 1ns / 1ps
module srmp_front #(
  parameter int RING_DEPTH = srmp_pkg::RING_DEPTH_DEF,
  parameter int USED_W     = $clog2(RING_DEPTH + 1),
  parameter int JOB_W      = $bits(srmp_pkg::job_t) + USED_W
) (
  input  logic                        clk,
  input  logic                        rst,
  srmp_in_if.sink                     req,
  input  logic [srmp_pkg::RATE_W-1:0] content_rate,
  output logic                        job_valid,
  input  logic                        job_ready,
  output logic [JOB_W-1:0]            job_data
);

  localparam int SPAN  = 2 * RING_DEPTH;
  localparam int CNT_W = $clog2(SPAN);
  localparam int CW1   = CNT_W + 1;
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int SUM_W = srmp_pkg::PHASE_W + 1;

  logic [CNT_W-1:0]             wcnt;
  logic [CNT_W-1:0]             rcnt;
  logic [srmp_pkg::PHASE_W-1:0] phase;
  logic [CW1-1:0]               occ;
  logic                         full;
  logic                         empty;
  logic                         accept;
  logic                         do_write;
  logic                         do_read;
  logic [SUM_W-1:0]             phase_sum;
  logic                         wrap;
  logic [USED_W-1:0]            used_next;
  logic [IDX_W-1:0]             widx;
  logic [IDX_W-1:0]             ridx;
  logic [srmp_pkg::FRAME_W-1:0] wdata;
  logic [srmp_pkg::FRAME_W-1:0] rdata;

  logic                                   pend_valid;
  logic                                   pend_kind;
  logic                                   pend_under;
  logic                                   pend_drop;
  logic [USED_W-1:0]                      pend_used;
  logic signed [srmp_pkg::PLAYER_W-1:0]   pend_pl;
  logic signed [srmp_pkg::PLAYER_W-1:0]   pend_pr;
  srmp_pkg::job_t                         job;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    return (CW1'(c) == CW1'(SPAN - 1)) ? '0 : c + CNT_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] cnt_idx(input logic [CNT_W-1:0] c);
    logic [CW1-1:0] r;
    r = (CW1'(c) >= CW1'(RING_DEPTH)) ? CW1'(c) - CW1'(RING_DEPTH) : CW1'(c);
    return r[IDX_W-1:0];
  endfunction

  assign occ = (wcnt >= rcnt) ? CW1'(wcnt) - CW1'(rcnt)
                              : CW1'(wcnt) + CW1'(SPAN) - CW1'(rcnt);
  assign full  = occ >= CW1'(RING_DEPTH);
  assign empty = occ == '0;

  assign req.ready = !pend_valid;
  assign accept    = req.valid && req.ready;
  assign do_write  = accept && req.kind == srmp_pkg::KIND_PUSH && !full;
  assign do_read   = accept && req.kind == srmp_pkg::KIND_FRAME && !empty;

  assign phase_sum = SUM_W'(phase) + SUM_W'(content_rate);
  assign wrap      = phase_sum >= SUM_W'(srmp_pkg::OUT_RATE);

  always_comb begin
    if (req.kind == srmp_pkg::KIND_PUSH) begin
      used_next = full ? USED_W'(occ) : USED_W'(occ + CW1'(1));
    end else if (empty) begin
      used_next = '0;
    end else if (wrap) begin
      used_next = USED_W'(occ - CW1'(1));
    end else begin
      used_next = USED_W'(occ);
    end
  end

  // offset bytes: (s + 32768) >> 8 flips the sign bit of the high byte
  assign wdata = {~req.sample_left[15], req.sample_left[14:8],
                  ~req.sample_right[15], req.sample_right[14:8]};
  assign widx  = cnt_idx(wcnt);
  assign ridx  = cnt_idx(rcnt);

  srmp_ram #(
    .WIDTH (srmp_pkg::FRAME_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (do_write),
    .waddr (widx),
    .wdata (wdata),
    .re    (do_read),
    .raddr (ridx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt       <= '0;
      rcnt       <= '0;
      phase      <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (pend_valid && job_ready) begin
        pend_valid <= 1'b0;
      end
      if (do_write) begin
        wcnt <= cnt_inc(wcnt);
      end
      if (do_read) begin
        if (wrap) begin
          phase <= srmp_pkg::PHASE_W'(phase_sum - SUM_W'(srmp_pkg::OUT_RATE));
          rcnt  <= cnt_inc(rcnt);
        end else begin
          phase <= srmp_pkg::PHASE_W'(phase_sum);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_kind  <= req.kind;
      pend_under <= req.kind == srmp_pkg::KIND_FRAME && empty;
      pend_drop  <= req.kind == srmp_pkg::KIND_PUSH && full;
      pend_used  <= used_next;
      pend_pl    <= req.player_left;
      pend_pr    <= req.player_right;
    end
  end

  always_comb begin
    job.kind         = pend_kind;
    job.underrun     = pend_under;
    job.dropped      = pend_drop;
    job.frame        = rdata;
    job.player_left  = pend_pl;
    job.player_right = pend_pr;
  end

  assign job_valid = pend_valid;
  assign job_data  = {job, pend_used};

endmodule

FILE: rtl/srmp_queue.sv
// short request queue between front and back
`timescale 1ns / 1ps
module srmp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = srmp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             enq_valid,
  output logic             enq_ready,
  input  logic [WIDTH-1:0] enq_data,
  output logic             deq_valid,
  input  logic             deq_ready,
  output logic [WIDTH-1:0] deq_data
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   slot [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [COUNT_W-1:0] count;
  logic               push;
  logic               pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign enq_ready = count != COUNT_W'(DEPTH);
  assign deq_valid = count != '0;
  assign push      = enq_valid && enq_ready;
  assign pop       = deq_valid && deq_ready;
  assign deq_data  = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ptr_inc(wptr);
      end
      if (pop) begin
        rptr <= ptr_inc(rptr);
      end
      if (push && !pop) begin
        count <= count + COUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= enq_data;
    end
  end

endmodule

FILE: rtl/srmp_back.sv
// back end: tone, mix, clip, pwm mapping and volume scaling
`timescale 1ns / 1ps
module srmp_back #(
  parameter int USED_W = $clog2(srmp_pkg::RING_DEPTH_DEF + 1),
  parameter int JOB_W  = $bits(srmp_pkg::job_t) + USED_W
) (
  input  logic               clk,
  input  logic               rst,
  input  srmp_pkg::mix_cfg_t cfg,
  input  logic               job_valid,
  output logic               job_ready,
  input  logic [JOB_W-1:0]   job_data,
  srmp_out_if.source         rsp
);

  localparam int MIX_W    = 19;
  localparam int SUM_W    = srmp_pkg::PHASE_W + 1;
  localparam int PROD_W   = srmp_pkg::SAMPLE_W + srmp_pkg::PWM_W;
  localparam int LV_W     = srmp_pkg::PWM_W + srmp_pkg::SCALE_W;
  localparam int LVS_W    = LV_W - 8;

  srmp_pkg::job_t               job;
  logic [USED_W-1:0]            job_used;
  logic                         stall;
  logic                         pop;
  logic [srmp_pkg::PHASE_W-1:0] tone_acc;
  logic [SUM_W-1:0]             tone_sum;
  logic [srmp_pkg::PHASE_W-1:0] tone_next;
  logic signed [MIX_W-1:0]      tone_term;
  logic                         tone_step;
  logic [srmp_pkg::PWM_W-1:0]   ul;
  logic [srmp_pkg::PWM_W-1:0]   ur;

  logic                         a_valid;
  logic                         a_kind;
  logic                         a_under;
  logic                         a_drop;
  logic [USED_W-1:0]            a_used;
  logic [srmp_pkg::PWM_W-1:0]   a_ul;
  logic [srmp_pkg::PWM_W-1:0]   a_ur;

  logic                         out_valid;
  logic [srmp_pkg::PWM_W-1:0]   out_pl;
  logic [srmp_pkg::PWM_W-1:0]   out_pr;
  logic                         out_under;
  logic                         out_drop;
  logic [USED_W-1:0]            out_used;

  // mix one channel, clip to int16, map to 0..PWM_TOP
  function automatic logic [srmp_pkg::PWM_W-1:0] mix_map(
    input logic [7:0]                        ring_byte,
    input logic                              silent,
    input logic signed [srmp_pkg::PLAYER_W-1:0] player,
    input logic signed [MIX_W-1:0]           tone
  );
    logic signed [MIX_W-1:0] ring;
    logic signed [MIX_W-1:0] sum;
    logic [15:0]             off;
    logic [PROD_W-1:0]       prod;
    ring = silent ? '0 : MIX_W'(signed'({~ring_byte[7], ring_byte[6:0], 8'h00}));
    sum  = ring + MIX_W'(player) + tone;
    if (sum > MIX_W'(32767)) begin
      off = 16'hffff;
    end else if (sum < -MIX_W'(32768)) begin
      off = 16'h0000;
    end else begin
      off = {~sum[15], sum[14:0]};
    end
    prod = PROD_W'(off) * PROD_W'(srmp_pkg::PWM_SPAN);
    return prod[PROD_W-1:16];
  endfunction

  function automatic logic [srmp_pkg::PWM_W-1:0] scale_clamp(
    input logic [srmp_pkg::PWM_W-1:0] u,
    input logic [srmp_pkg::SCALE_W-1:0] s
  );
    logic [LV_W-1:0]  prod;
    logic [LVS_W-1:0] lv;
    prod = LV_W'(u) * LV_W'(s);
    lv   = prod[LV_W-1:8];
    return (lv > LVS_W'(srmp_pkg::PWM_TOP)) ? srmp_pkg::PWM_W'(srmp_pkg::PWM_TOP)
                                            : srmp_pkg::PWM_W'(lv);
  endfunction

  assign job      = job_data[USED_W +: $bits(srmp_pkg::job_t)];
  assign job_used = job_data[USED_W-1:0];

  assign stall     = out_valid && !rsp.ready;
  assign job_ready = !stall;
  assign pop       = job_valid && job_ready;

  assign tone_sum  = SUM_W'(tone_acc) + SUM_W'(cfg.tone_freq);
  assign tone_next = (tone_sum >= SUM_W'(srmp_pkg::OUT_RATE))
                   ? srmp_pkg::PHASE_W'(tone_sum - SUM_W'(srmp_pkg::OUT_RATE))
                   : srmp_pkg::PHASE_W'(tone_sum);
  assign tone_step = pop && job.kind == srmp_pkg::KIND_FRAME && cfg.tone_enable;

  always_comb begin
    if (!cfg.tone_enable) begin
      tone_term = '0;
    end else if (tone_next >= srmp_pkg::PHASE_W'(srmp_pkg::HALF_RATE)) begin
      tone_term = -MIX_W'({cfg.tone_level, 7'd0});
    end else begin
      tone_term = MIX_W'({cfg.tone_level, 7'd0});
    end
  end

  assign ul = mix_map(job.frame[15:8], job.underrun, job.player_left, tone_term);
  assign ur = mix_map(job.frame[7:0], job.underrun, job.player_right, tone_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_acc   <= '0;
      a_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.tone_clear) begin
        tone_acc <= '0;
      end else if (tone_step) begin
        tone_acc <= tone_next;
      end
      if (!stall) begin
        a_valid   <= pop;
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      a_kind    <= job.kind;
      a_under   <= job.underrun;
      a_drop    <= job.dropped;
      a_used    <= job_used;
      a_ul      <= ul;
      a_ur      <= ur;
      out_under <= a_under;
      out_drop  <= a_drop;
      out_used  <= a_used;
      out_pl    <= (a_kind == srmp_pkg::KIND_FRAME) ? scale_clamp(a_ul, cfg.scale) : '0;
      out_pr    <= (a_kind == srmp_pkg::KIND_FRAME) ? scale_clamp(a_ur, cfg.scale) : '0;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.pwm_left   = out_pl;
  assign rsp.pwm_right  = out_pr;
  assign rsp.underrun   = out_under;
  assign rsp.dropped    = out_drop;
  assign rsp.fill_level = out_used;

endmodule

FILE: rtl/stereo_ring_mixer_pwm.sv
// top level: stereo ring buffer, mixer and pwm level mapper
//
// req carries push requests (kind 0, a stereo int16 pair written into the
// ring as offset bytes) and frame requests (kind 1, player sums mixed with one
// resampled ring frame and an optional square tone). rsp returns one result per
// request, in order: pwm levels, underrun, dropped and ring occupancy.
// a request is taken when req.valid and req.ready are high at a clock edge.
// the front holds each request in a pending register while the ring ram
// answers and takes no new request until that one has gone to the queue;
// the ram read latency sets this. a result passes the pending register, the
// queue and the back's a and out stages. a stalled rsp holds its result; the
// two-entry queue and pending register absorb requests until req.ready drops.
// configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are to be made only while the block is idle; the block does not enforce it.
// rst is synchronous: the ring empties, phases clear and registers return to
// volume 100, tone off, 440 hz, content rate 44100. no clearing pass is needed.
`timescale 1ns / 1ps
module stereo_ring_mixer_pwm #(
  parameter int RING_DEPTH = srmp_pkg::RING_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  srmp_in_if.sink                        req,
  srmp_out_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [srmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srmp_pkg::CFG_W-1:0]     cfg_data
);

  localparam int USED_W = $clog2(RING_DEPTH + 1);
  localparam int JOB_W  = $bits(srmp_pkg::job_t) + USED_W;

  logic [srmp_pkg::VOL_W-1:0]        vol_sat;
  logic [srmp_pkg::SCALE_PROD_W-1:0] scale_prod;
  logic [srmp_pkg::FREQ_W-1:0]       freq_raw;
  logic [srmp_pkg::FREQ_W-1:0]       freq_sat;
  logic [srmp_pkg::RATE_W-1:0]       rate_sat;
  logic                              tone_enable;
  logic [srmp_pkg::FREQ_W-1:0]       tone_freq;
  logic [srmp_pkg::LEVEL_W-1:0]      tone_level;
  logic [srmp_pkg::SCALE_W-1:0]      scale;
  logic [srmp_pkg::RATE_W-1:0]       content_rate;
  logic                              tone_clear;
  srmp_pkg::mix_cfg_t                mix_cfg;

  logic              fj_valid;
  logic              fj_ready;
  logic [JOB_W-1:0]  fj_data;
  logic              bj_valid;
  logic              bj_ready;
  logic [JOB_W-1:0]  bj_data;

  assign vol_sat = (cfg_data[srmp_pkg::VOL_W-1:0] > srmp_pkg::VOL_W'(srmp_pkg::VOL_MAX))
                 ? srmp_pkg::VOL_W'(srmp_pkg::VOL_MAX) : cfg_data[srmp_pkg::VOL_W-1:0];
  assign scale_prod = srmp_pkg::SCALE_PROD_W'(vol_sat)
                    * srmp_pkg::SCALE_PROD_W'(srmp_pkg::SCALE_RECIP);
  assign freq_raw = cfg_data[srmp_pkg::FREQ_W-1:0];
  assign freq_sat = (freq_raw < srmp_pkg::FREQ_W'(srmp_pkg::FREQ_MIN))
                  ? srmp_pkg::FREQ_W'(srmp_pkg::FREQ_MIN)
                  : (freq_raw > srmp_pkg::FREQ_W'(srmp_pkg::FREQ_MAX))
                  ? srmp_pkg::FREQ_W'(srmp_pkg::FREQ_MAX) : freq_raw;
  assign rate_sat = (32'(cfg_data) > srmp_pkg::OUT_RATE)
                  ? srmp_pkg::RATE_W'(srmp_pkg::OUT_RATE) : srmp_pkg::RATE_W'(cfg_data);

  assign tone_clear = cfg_we
                   && (srmp_pkg::reg_idx_t'(cfg_index) == srmp_pkg::REG_TONE_ENABLE
                    || srmp_pkg::reg_idx_t'(cfg_index) == srmp_pkg::REG_TONE_FREQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= srmp_pkg::SCALE_W'(srmp_pkg::SCALE_RESET);
      tone_level   <= srmp_pkg::LEVEL_W'(srmp_pkg::LEVEL_RESET);
      tone_enable  <= 1'b0;
      tone_freq    <= srmp_pkg::FREQ_W'(srmp_pkg::FREQ_RESET);
      content_rate <= srmp_pkg::RATE_W'(srmp_pkg::OUT_RATE);
    end else if (cfg_we) begin
      unique case (srmp_pkg::reg_idx_t'(cfg_index))
        srmp_pkg::REG_VOLUME: begin
          scale      <= scale_prod[srmp_pkg::SCALE_SHIFT +: srmp_pkg::SCALE_W];
          tone_level <= srmp_pkg::LOG_LEVEL[vol_sat];
        end
        srmp_pkg::REG_TONE_ENABLE: begin
          tone_enable <= cfg_data[0];
        end
        srmp_pkg::REG_TONE_FREQ: begin
          tone_freq <= freq_sat;
        end
        srmp_pkg::REG_CONTENT_RATE: begin
          content_rate <= rate_sat;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mix_cfg.tone_enable = tone_enable;
    mix_cfg.tone_clear  = tone_clear;
    mix_cfg.tone_freq   = tone_freq;
    mix_cfg.tone_level  = tone_level;
    mix_cfg.scale       = scale;
  end

  srmp_front #(
    .RING_DEPTH (RING_DEPTH),
    .USED_W     (USED_W),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .content_rate (content_rate),
    .job_valid    (fj_valid),
    .job_ready    (fj_ready),
    .job_data     (fj_data)
  );

  srmp_queue #(
    .WIDTH (JOB_W),
    .DEPTH (srmp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq_valid (fj_valid),
    .enq_ready (fj_ready),
    .enq_data  (fj_data),
    .deq_valid (bj_valid),
    .deq_ready (bj_ready),
    .deq_data  (bj_data)
  );

  srmp_back #(
    .USED_W (USED_W),
    .JOB_W  (JOB_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (mix_cfg),
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job_data  (bj_data),
    .rsp       (rsp)
  );

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> 32'(rsp.fill_level) <= RING_DEPTH)
    else $error("ring occupancy above depth");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.underrun && rsp.dropped))
    else $error("underrun and dropped together");

  a_under_empty: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.underrun |-> rsp.fill_level == '0)
    else $error("underrun with data in ring");

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.dropped |-> rsp.pwm_left == '0 && rsp.pwm_right == '0
                              && 32'(rsp.fill_level) == RING_DEPTH)
    else $error("dropped push with pwm level or ring not full");

endmodule
